@@ hdl/pmid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_pkg
// Shared types, constants and helpers for the periodic minimum-image
// distance pipeline.
// ----------------------------------------------------------------------------
package pmid_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int PORT_W          = 32;
  localparam int BOX_W           = 31;
  localparam int POS_W           = 33;
  localparam int DIST_W          = 63;
  localparam int SQ_W            = 64;
  localparam int ROOT_W          = 32;
  localparam int IDX_W           = 3;
  localparam int LANES           = 6;
  localparam int AXES            = 3;

  localparam logic [DIST_W-1:0] MAX_DIST = {DIST_W{1'b1}};

  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_X = 3'd0,
    REG_BOX_Y = 3'd1,
    REG_BOX_Z = 3'd2,
    REG_WRAP  = 3'd3,
    REG_ROOT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BOX_W-1:0] len_x;
    logic [BOX_W-1:0] len_y;
    logic [BOX_W-1:0] len_z;
    logic             wrap;
    logic             root;
  } cfg_t;

  // Box edge for one axis.
  function automatic logic [BOX_W-1:0] axis_len(cfg_t cfg, int axis);
    logic [BOX_W-1:0] l;
    case (axis)
      0:       l = cfg.len_x;
      1:       l = cfg.len_y;
      default: l = cfg.len_z;
    endcase
    return l;
  endfunction

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic logic [BOX_W-1:0] mod_step(logic [BOX_W-1:0] rem, logic din,
                                                logic [BOX_W-1:0] len);
    logic [BOX_W:0] sh;
    sh = {rem, din};
    if (sh >= {1'b0, len}) begin
      sh = sh - {1'b0, len};
    end
    return sh[BOX_W-1:0];
  endfunction

endpackage

@@ hdl/pmid_fold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_fold
// Folds six coordinates into the box: a bit-per-stage remainder pipeline
// followed by a register that picks the folded or raw coordinate.
// ----------------------------------------------------------------------------
module pmid_fold #(
  parameter int COORD_WIDTH = pmid_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               valid,
  input  logic [pmid_pkg::PORT_W-1:0]        coord [pmid_pkg::LANES],
  input  pmid_pkg::cfg_t                     cfg,
  output logic                               pos_valid,
  output logic signed [pmid_pkg::POS_W-1:0]  pos [pmid_pkg::LANES]
);

  localparam int NS = COORD_WIDTH + 1;

  logic [COORD_WIDTH-1:0]       x_s   [pmid_pkg::LANES][NS];
  logic [COORD_WIDTH-1:0]       mag_s [pmid_pkg::LANES][NS];
  logic [pmid_pkg::BOX_W-1:0]   rem_s [pmid_pkg::LANES][NS];
  logic                         valid_s [NS];

  // Advance the valid bits with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        valid_s[k] <= 1'b0;
      end
      pos_valid <= 1'b0;
    end else if (en) begin
      valid_s[0] <= valid;
      for (int k = 1; k < NS; k++) begin
        valid_s[k] <= valid_s[k-1];
      end
      pos_valid <= valid_s[NS-1];
    end
  end

  for (genvar l = 0; l < pmid_pkg::LANES; l++) begin : g_lane
    logic [pmid_pkg::BOX_W-1:0]    len;
    logic [COORD_WIDTH-1:0]        x_in;
    logic [COORD_WIDTH-1:0]        x_out;
    logic [pmid_pkg::BOX_W-1:0]    r;
    logic signed [pmid_pkg::POS_W-1:0] raw;
    logic signed [pmid_pkg::POS_W-1:0] pos_next;

    assign len  = pmid_pkg::axis_len(cfg, l % pmid_pkg::AXES);
    assign x_in = coord[l][COORD_WIDTH-1:0];

    // Load the coordinate and its magnitude.
    always_ff @(posedge clk) begin
      if (en) begin
        x_s[l][0]   <= x_in;
        mag_s[l][0] <= x_in[COORD_WIDTH-1] ? (~x_in + 1'b1) : x_in;
        rem_s[l][0] <= '0;
      end
    end

    // One remainder bit per stage, most significant first.
    for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_step
      always_ff @(posedge clk) begin
        if (en) begin
          x_s[l][k+1]   <= x_s[l][k];
          mag_s[l][k+1] <= mag_s[l][k] << 1;
          rem_s[l][k+1] <= pmid_pkg::mod_step(rem_s[l][k], mag_s[l][k][COORD_WIDTH-1],
                                              len);
        end
      end
    end

    assign x_out = x_s[l][NS-1];
    assign r     = rem_s[l][NS-1];
    assign raw   = {{(pmid_pkg::POS_W-COORD_WIDTH){x_out[COORD_WIDTH-1]}}, x_out};

    // Pick the folded value; a positive exact multiple lands on the edge.
    always_comb begin
      if (!cfg.wrap || len == '0) begin
        pos_next = raw;
      end else if (x_out[COORD_WIDTH-1]) begin
        pos_next = (r == '0) ? '0 : signed'(pmid_pkg::POS_W'(len - r));
      end else if (x_out == '0) begin
        pos_next = '0;
      end else if (r == '0) begin
        pos_next = signed'(pmid_pkg::POS_W'(len));
      end else begin
        pos_next = signed'(pmid_pkg::POS_W'(r));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pos[l] <= pos_next;
      end
    end
  end

endmodule

@@ hdl/pmid_dist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_dist
// Nearest-image difference per axis, squares and the saturating sum,
// in four register stages.
// ----------------------------------------------------------------------------
module pmid_dist (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               valid,
  input  logic signed [pmid_pkg::POS_W-1:0]  pos [pmid_pkg::LANES],
  input  pmid_pkg::cfg_t                     cfg,
  output logic                               sum_valid,
  output logic [pmid_pkg::DIST_W-1:0]        sum,
  output logic                               sum_sat
);

  localparam int DX_W = pmid_pkg::POS_W + 1;
  localparam int TW_W = pmid_pkg::POS_W + 2;

  logic [pmid_pkg::ROOT_W-1:0] mag [pmid_pkg::AXES];
  logic [pmid_pkg::SQ_W-1:0]   sq  [pmid_pkg::AXES];
  logic [pmid_pkg::DIST_W-1:0] sxy;
  logic [pmid_pkg::DIST_W-1:0] sz;
  logic                        sat3;
  logic [2:0]                  valid_s;

  logic [pmid_pkg::SQ_W-1:0]   sxy_full;
  logic [pmid_pkg::SQ_W-1:0]   tot_full;
  logic [pmid_pkg::DIST_W-1:0] sq_c [pmid_pkg::AXES];
  logic                        sq_o [pmid_pkg::AXES];

  // Advance the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s   <= '0;
      sum_valid <= 1'b0;
    end else if (en) begin
      valid_s   <= {valid_s[1:0], valid};
      sum_valid <= valid_s[2];
    end
  end

  for (genvar a = 0; a < pmid_pkg::AXES; a++) begin : g_axis
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dx_img;
    logic signed [TW_W-1:0] two_dx;
    logic signed [TW_W-1:0] len_s;
    logic signed [DX_W-1:0] len_d;
    logic [DX_W-1:0]        dx_abs;

    assign len_s  = signed'(TW_W'(pmid_pkg::axis_len(cfg, a)));
    assign len_d  = signed'(DX_W'(pmid_pkg::axis_len(cfg, a)));
    assign dx     = DX_W'(pos[a]) - DX_W'(pos[a + pmid_pkg::AXES]);
    assign two_dx = {dx, 1'b0};

    // Move the difference to the nearest image.
    always_comb begin
      if (two_dx > len_s) begin
        dx_img = dx - len_d;
      end else if (two_dx < -len_s) begin
        dx_img = dx + len_d;
      end else begin
        dx_img = dx;
      end
      dx_abs = dx_img[DX_W-1] ? DX_W'(-dx_img) : DX_W'(dx_img);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag[a] <= dx_abs[pmid_pkg::ROOT_W-1:0];
        sq[a]  <= pmid_pkg::SQ_W'(mag[a]) * pmid_pkg::SQ_W'(mag[a]);
      end
    end

    // Clamp each square.
    assign sq_o[a] = sq[a][pmid_pkg::SQ_W-1];
    assign sq_c[a] = sq_o[a] ? pmid_pkg::MAX_DIST : sq[a][pmid_pkg::DIST_W-1:0];
  end

  assign sxy_full = pmid_pkg::SQ_W'(sq_c[0]) + pmid_pkg::SQ_W'(sq_c[1]);
  assign tot_full = pmid_pkg::SQ_W'(sxy) + pmid_pkg::SQ_W'(sz);

  // Sum with saturation over two stages.
  always_ff @(posedge clk) begin
    if (en) begin
      sxy     <= sxy_full[pmid_pkg::SQ_W-1] ? pmid_pkg::MAX_DIST
                                            : sxy_full[pmid_pkg::DIST_W-1:0];
      sz      <= sq_c[2];
      sat3    <= sq_o[0] | sq_o[1] | sq_o[2] | sxy_full[pmid_pkg::SQ_W-1];
      sum     <= tot_full[pmid_pkg::SQ_W-1] ? pmid_pkg::MAX_DIST
                                            : tot_full[pmid_pkg::DIST_W-1:0];
      sum_sat <= sat3 | tot_full[pmid_pkg::SQ_W-1];
    end
  end

endmodule

@@ hdl/pmid_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmid_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// with a final register that selects root or squared sum.
// ----------------------------------------------------------------------------
module pmid_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid,
  input  logic [pmid_pkg::DIST_W-1:0]  sum,
  input  logic                         sat,
  input  logic                         root_en,
  output logic                         dist_valid,
  output logic [pmid_pkg::DIST_W-1:0]  dist_value,
  output logic                         dist_sat
);

  localparam int NS    = pmid_pkg::ROOT_W + 1;
  localparam int REM_W = pmid_pkg::ROOT_W + 3;

  logic [pmid_pkg::SQ_W-1:0]   v_s    [NS];
  logic [pmid_pkg::DIST_W-1:0] sum_s  [NS];
  logic                        sat_s  [NS];
  logic [REM_W-1:0]            rem_s  [NS];
  logic [pmid_pkg::ROOT_W-1:0] root_s [NS];
  logic                        valid_s [NS];

  // Advance the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        valid_s[k] <= 1'b0;
      end
      dist_valid <= 1'b0;
    end else if (en) begin
      valid_s[0] <= valid;
      for (int k = 1; k < NS; k++) begin
        valid_s[k] <= valid_s[k-1];
      end
      dist_valid <= valid_s[NS-1];
    end
  end

  // Load the radicand.
  always_ff @(posedge clk) begin
    if (en) begin
      v_s[0]    <= {1'b0, sum};
      sum_s[0]  <= sum;
      sat_s[0]  <= sat;
      rem_s[0]  <= '0;
      root_s[0] <= '0;
    end
  end

  for (genvar k = 0; k < pmid_pkg::ROOT_W; k++) begin : g_step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {rem_s[k][REM_W-3:0], v_s[k][pmid_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_s[k], 2'b01};

    // Take one root bit.
    always_ff @(posedge clk) begin
      if (en) begin
        v_s[k+1]   <= v_s[k] << 2;
        sum_s[k+1] <= sum_s[k];
        sat_s[k+1] <= sat_s[k];
        if (rem_sh >= trial) begin
          rem_s[k+1]  <= rem_sh - trial;
          root_s[k+1] <= {root_s[k][pmid_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_s[k+1]  <= rem_sh;
          root_s[k+1] <= {root_s[k][pmid_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Hold the result beat.
  always_ff @(posedge clk) begin
    if (en) begin
      dist_value <= root_en ? pmid_pkg::DIST_W'(root_s[NS-1]) : sum_s[NS-1];
      dist_sat   <= sat_s[NS-1];
    end
  end

endmodule

@@ hdl/periodic_min_image_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_min_image_distance
// Minimum-image distance between two atoms in an orthorhombic periodic box.
//
// Input channel pair_valid/pair_stall carries one atom pair per beat; the
// output channel dist_valid/dist_stall returns one distance beat per pair,
// in order. The user must write box edges and wrap/root modes via cfg_write/
// cfg_index/cfg_data only while the block is empty; this is not enforced.
//
// Throughput is one pair per clock while no result is held by dist_stall.
// A pair passes through the remainder pipeline that folds coordinates into
// the box, the image shift, squares and sum, and the square-root pipeline
// and output register.
//
// All stages move together. When dist_stall holds a valid result, the whole
// pipeline freezes and pair_stall rises, so no beat is lost or repeated.
// Reset clears every valid bit and restores box edges of 65536 with both modes
// off; payload registers are not reset.
// ----------------------------------------------------------------------------
module periodic_min_image_distance #(
  parameter int COORD_WIDTH = pmid_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pmid_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pmid_pkg::BOX_W-1:0]         cfg_data,
  input  logic                               pair_valid,
  output logic                               pair_stall,
  input  logic signed [pmid_pkg::PORT_W-1:0] first_x,
  input  logic signed [pmid_pkg::PORT_W-1:0] first_y,
  input  logic signed [pmid_pkg::PORT_W-1:0] first_z,
  input  logic signed [pmid_pkg::PORT_W-1:0] second_x,
  input  logic signed [pmid_pkg::PORT_W-1:0] second_y,
  input  logic signed [pmid_pkg::PORT_W-1:0] second_z,
  output logic                               dist_valid,
  input  logic                               dist_stall,
  output logic [pmid_pkg::DIST_W-1:0]        distance_value,
  output logic                               saturated
);

  pmid_pkg::cfg_t cfg;

  logic                               en;
  logic [pmid_pkg::PORT_W-1:0]        coord [pmid_pkg::LANES];
  logic                               pos_valid;
  logic signed [pmid_pkg::POS_W-1:0]  pos [pmid_pkg::LANES];
  logic                               sum_valid;
  logic [pmid_pkg::DIST_W-1:0]        sum;
  logic                               sum_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.len_x <= pmid_pkg::BOX_RESET;
      cfg.len_y <= pmid_pkg::BOX_RESET;
      cfg.len_z <= pmid_pkg::BOX_RESET;
      cfg.wrap  <= 1'b0;
      cfg.root  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pmid_pkg::REG_BOX_X: cfg.len_x <= cfg_data;
        pmid_pkg::REG_BOX_Y: cfg.len_y <= cfg_data;
        pmid_pkg::REG_BOX_Z: cfg.len_z <= cfg_data;
        pmid_pkg::REG_WRAP:  cfg.wrap  <= cfg_data[0];
        pmid_pkg::REG_ROOT:  cfg.root  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a finished beat is held at the output.
  assign en         = !dist_valid || !dist_stall;
  assign pair_stall = !en;

  assign coord[0] = first_x;
  assign coord[1] = first_y;
  assign coord[2] = first_z;
  assign coord[3] = second_x;
  assign coord[4] = second_y;
  assign coord[5] = second_z;

  pmid_fold #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (pair_valid),
    .coord     (coord),
    .cfg       (cfg),
    .pos_valid (pos_valid),
    .pos       (pos)
  );

  pmid_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (pos_valid),
    .pos       (pos),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_sat   (sum_sat)
  );

  pmid_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid      (sum_valid),
    .sum        (sum),
    .sat        (sum_sat),
    .root_en    (cfg.root),
    .dist_valid (dist_valid),
    .dist_value (distance_value),
    .dist_sat   (saturated)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic minimum-image distance block. A queue
// of atom pairs feeds a clocked driver. Each accepted pair is run through a
// behavioral distance predictor under the current box setup. A clocked
// monitor compares every distance beat with the oldest prediction. The run
// steps through several box and mode settings, and both channels idle at
// random in all but the last two random phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [63:0] CLAMP63   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          DRAIN_CYC = 100;
  localparam int          HANG_CYC  = 20000;

  typedef struct {
    logic signed [pmid_pkg::PORT_W-1:0] c [pmid_pkg::LANES];
  } atom_pair_t;

  typedef struct {
    logic [pmid_pkg::DIST_W-1:0] value;
    logic                        sat;
  } dist_beat_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [pmid_pkg::IDX_W-1:0]         cfg_index = '0;
  logic [pmid_pkg::BOX_W-1:0]         cfg_data = '0;
  logic                               pair_valid = 1'b0;
  logic                               pair_stall;
  logic signed [pmid_pkg::PORT_W-1:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [pmid_pkg::PORT_W-1:0] second_x = '0, second_y = '0, second_z = '0;
  logic                               dist_valid;
  logic                               dist_stall = 1'b0;
  logic [pmid_pkg::DIST_W-1:0]        distance_value;
  logic                               saturated;

  // Current box setup as the block should see it
  longint     edge_len [pmid_pkg::AXES];
  bit         wrap_on, root_on;
  int         send_idle_pct, recv_stall_pct;
  atom_pair_t pair_q [$];
  dist_beat_t dist_expect_q [$];
  int         mismatch_cnt;
  int         hang_cnt;

  periodic_min_image_distance dut (.*);

  always #5 clk = ~clk;

  // Fold a coordinate into [0,L], a positive exact multiple going to L
  function automatic longint fold_coord(longint x, longint len);
    longint r;
    if (len == 0) return x;
    if (x > 0) begin
      r = x % len;
      return (r == 0) ? len : r;
    end
    if (x < 0) begin
      r = (-x) % len;
      return (r == 0) ? 0 : len - r;
    end
    return 0;
  endfunction

  // Nearest-image axis difference, squared
  function automatic logic [63:0] image_square(longint a, longint b, longint len);
    longint      dx;
    logic [63:0] m;
    dx = a - b;
    if (2 * dx > len) dx -= len;
    else if (2 * dx < -len) dx += len;
    m = (dx < 0) ? -dx : dx;
    return m * m;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic dist_beat_t pair_distance(atom_pair_t p);
    longint      pos [pmid_pkg::LANES];
    logic [63:0] sum, sq;
    dist_beat_t  d;
    d.sat = 1'b0;
    for (int k = 0; k < pmid_pkg::LANES; k++) begin
      pos[k] = longint'(p.c[k]);
      if (wrap_on) pos[k] = fold_coord(pos[k], edge_len[k % pmid_pkg::AXES]);
    end
    sum = 0;
    for (int k = 0; k < pmid_pkg::AXES; k++) begin
      sq = image_square(pos[k], pos[k + pmid_pkg::AXES], edge_len[k]);
      if (sq > CLAMP63) begin
        sq    = CLAMP63;
        d.sat = 1'b1;
      end
      sum = sum + sq;
      if (sum > CLAMP63) begin
        sum   = CLAMP63;
        d.sat = 1'b1;
      end
    end
    if (root_on) sum = floor_root(sum);
    d.value = sum[pmid_pkg::DIST_W-1:0];
    return d;
  endfunction

  // Coordinate near the interesting points of an edge (multiples, offsets) or fully random
  function automatic logic [pmid_pkg::PORT_W-1:0] pick_coord(longint len);
    longint k;
    k = longint'($urandom_range(6)) - 3;
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return pmid_pkg::PORT_W'(k * len);
      2:       return pmid_pkg::PORT_W'(k * len + longint'($urandom_range(4)) - 2);
      default: return pmid_pkg::PORT_W'($urandom_range(1) ? -longint'($urandom_range(len))
                                                         : longint'($urandom_range(len)));
    endcase
  endfunction

  function automatic atom_pair_t random_pair();
    atom_pair_t p;
    longint     half;
    for (int a = 0; a < pmid_pkg::AXES; a++) begin
      p.c[a] = pick_coord(edge_len[a]);
      // In one case of four put the second atom about half an edge away
      if ($urandom_range(3) == 0) begin
        half = (edge_len[a] + longint'($urandom_range(1))) >> 1;
        half = half + longint'($urandom_range(2)) - 1;
        p.c[a + pmid_pkg::AXES] = p.c[a] + pmid_pkg::PORT_W'($urandom_range(1) ? half
                                                                               : -half);
      end else begin
        p.c[a + pmid_pkg::AXES] = pick_coord(edge_len[a]);
      end
    end
    return p;
  endfunction

  function automatic atom_pair_t make_pair(longint ax, longint ay, longint az,
                                           longint bx, longint by, longint bz);
    atom_pair_t p;
    p.c[0] = pmid_pkg::PORT_W'(ax);
    p.c[1] = pmid_pkg::PORT_W'(ay);
    p.c[2] = pmid_pkg::PORT_W'(az);
    p.c[3] = pmid_pkg::PORT_W'(bx);
    p.c[4] = pmid_pkg::PORT_W'(by);
    p.c[5] = pmid_pkg::PORT_W'(bz);
    return p;
  endfunction

  // Append a pair to the pending queue
  task automatic queue_pair(atom_pair_t p);
    pair_q = {pair_q, p};
  endtask

  task automatic write_reg(pmid_pkg::cfg_reg_t idx, logic [pmid_pkg::BOX_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      pmid_pkg::REG_BOX_X: edge_len[0] = longint'(val);
      pmid_pkg::REG_BOX_Y: edge_len[1] = longint'(val);
      pmid_pkg::REG_BOX_Z: edge_len[2] = longint'(val);
      pmid_pkg::REG_WRAP:  wrap_on = val[0];
      pmid_pkg::REG_ROOT:  root_on = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every pair is sent and every distance is back, then settle
  task automatic drain();
    do @(negedge clk);
    while (pair_q.size() != 0 || pair_valid || dist_expect_q.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Driver: predict on acceptance, then present the next pair or go idle
  always @(posedge clk) begin
    atom_pair_t p;
    if (rst) begin
      pair_valid <= 1'b0;
    end else begin
      if (pair_valid && !pair_stall) begin
        p.c[0] = first_x;  p.c[1] = first_y;  p.c[2] = first_z;
        p.c[3] = second_x; p.c[4] = second_y; p.c[5] = second_z;
        dist_expect_q = {dist_expect_q, pair_distance(p)};
      end
      if (!pair_valid || !pair_stall) begin
        if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pair_q.pop_front();
          pair_valid <= 1'b1;
          first_x  <= p.c[0]; first_y  <= p.c[1]; first_z  <= p.c[2];
          second_x <= p.c[3]; second_y <= p.c[4]; second_z <= p.c[5];
        end else begin
          pair_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each distance beat against the oldest prediction
  always @(posedge clk) begin
    dist_beat_t e;
    if (rst) begin
      dist_stall <= 1'b0;
    end else begin
      if (dist_valid && !dist_stall) begin
        if (dist_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected distance beat: value=%h sat=%b", distance_value, saturated);
        end else begin
          e = dist_expect_q.pop_front();
          if (distance_value !== e.value || saturated !== e.sat) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("distance mismatch: exp value=%h sat=%b, got value=%h sat=%b",
                       e.value, e.sat, distance_value, saturated);
          end
        end
      end
      dist_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pair_valid && !pair_stall) || (dist_valid && !dist_stall) || cfg_write) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_CYC) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  initial begin
    logic [pmid_pkg::BOX_W-1:0] boxes [6][pmid_pkg::AXES];
    bit                         wraps [6], roots [6];
    int                         regime;
    send_idle_pct  = 11;
    recv_stall_pct = 67;
    edge_len[0] = 65536; edge_len[1] = 65536; edge_len[2] = 65536;
    wrap_on = 1'b0;
    root_on = 1'b0;

    // Hold reset
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs under the reset setup (reset box edges, no wrap, squared)
    queue_pair(make_pair(0, 0, 0, 0, 0, 0));
    queue_pair(make_pair(32'h7FFF_FFFF, 0, 0, -32'sh8000_0000, 0, 0));
    queue_pair(make_pair(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_pair(make_pair(32768, -32768, 32769, 0, 0, 0));
    queue_pair(make_pair(65536, -65536, 131072, 0, 1, -1));
    queue_pair(make_pair(-1, 1, 32767, 1, -1, -32767));
    drain();

    // Fold on: exact multiples, zero, half-box differences, then root, then fold off
    write_reg(pmid_pkg::REG_WRAP, 1);
    queue_pair(make_pair(65536, -65536, 0, 131072, -131072, 65535));
    queue_pair(make_pair(32768, 0, 1, 0, 32768, -1));
    queue_pair(make_pair(-32'sh8000_0000, 32'h7FFF_FFFF, 3, 7, -9, 65536 * 5));
    drain();
    write_reg(pmid_pkg::REG_ROOT, 1);
    queue_pair(make_pair(65536, 16384, -5, 0, 0, 0));
    queue_pair(make_pair(-32'sh8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
    drain();
    write_reg(pmid_pkg::REG_WRAP, 0);
    queue_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000));
    queue_pair(make_pair(12345, -54321, 999, -777, 65536, 1));
    drain();

    // Setting table for the random phases, extremes included
    boxes[0] = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF}; wraps[0] = 0; roots[0] = 0;
    boxes[1] = '{31'd1, 31'd1, 31'd1};                         wraps[1] = 1; roots[1] = 1;
    boxes[2] = '{pmid_pkg::BOX_W'($urandom()), pmid_pkg::BOX_W'($urandom()),
                 pmid_pkg::BOX_W'($urandom())};                wraps[2] = 1; roots[2] = 0;
    boxes[3] = '{pmid_pkg::BOX_W'(65536 * $urandom_range(1, 100)),
                 pmid_pkg::BOX_W'(65536 * $urandom_range(1, 100)),
                 pmid_pkg::BOX_W'($urandom_range(1, 4096))};   wraps[3] = 1; roots[3] = 1;
    boxes[4] = '{pmid_pkg::BOX_W'($urandom()), pmid_pkg::BOX_W'($urandom_range(1, 65536)),
                 pmid_pkg::BOX_W'($urandom())};
    wraps[4] = 0; roots[4] = 1;
    boxes[5] = '{31'h7FFF_FFFF, 31'd1, pmid_pkg::BOX_W'($urandom())};
    wraps[5] = 1; roots[5] = 0;

    for (int ph = 0; ph < 6; ph++) begin
      regime = ph / 2;
      send_idle_pct  = (regime == 0) ? 11 : (regime == 1) ? 67 : 0;
      recv_stall_pct = (regime == 0) ? 67 : (regime == 1) ? 11 : 0;
      for (int a = 0; a < pmid_pkg::AXES; a++) begin
        if (boxes[ph][a] == 0) boxes[ph][a] = 1;
        write_reg(pmid_pkg::cfg_reg_t'(pmid_pkg::REG_BOX_X + a), boxes[ph][a]);
      end
      write_reg(pmid_pkg::REG_WRAP, wraps[ph]);
      write_reg(pmid_pkg::REG_ROOT, roots[ph]);
      for (int n = 0; n < 250; n++) queue_pair(random_pair());
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
